/* design/c8x_pkg.sv */
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types and constants of the CHIP-8 execute unit.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int MEM_AW = 12;

  localparam logic [1:0] REQ_EXEC  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  localparam logic [3:0] OPC_SYS  = 4'h0;
  localparam logic [3:0] OPC_JP   = 4'h1;
  localparam logic [3:0] OPC_CALL = 4'h2;
  localparam logic [3:0] OPC_SEI  = 4'h3;
  localparam logic [3:0] OPC_SNEI = 4'h4;
  localparam logic [3:0] OPC_SER  = 4'h5;
  localparam logic [3:0] OPC_LDI  = 4'h6;
  localparam logic [3:0] OPC_ADDI = 4'h7;
  localparam logic [3:0] OPC_ALU  = 4'h8;
  localparam logic [3:0] OPC_SNER = 4'h9;
  localparam logic [3:0] OPC_LDIX = 4'hA;
  localparam logic [3:0] OPC_JPV0 = 4'hB;
  localparam logic [3:0] OPC_RND  = 4'hC;
  localparam logic [3:0] OPC_DRW  = 4'hD;
  localparam logic [3:0] OPC_KEY  = 4'hE;
  localparam logic [3:0] OPC_MISC = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KK_SKP   = 8'h9E;
  localparam logic [7:0] KK_SKNP  = 8'hA1;
  localparam logic [7:0] KK_GETDT = 8'h07;
  localparam logic [7:0] KK_WAIT  = 8'h0A;
  localparam logic [7:0] KK_SETDT = 8'h15;
  localparam logic [7:0] KK_SETST = 8'h18;
  localparam logic [7:0] KK_ADDI  = 8'h1E;
  localparam logic [7:0] KK_FONT  = 8'h29;
  localparam logic [7:0] KK_BCD   = 8'h33;
  localparam logic [7:0] KK_STORE = 8'h55;
  localparam logic [7:0] KK_LOAD  = 8'h65;

  localparam logic [15:0] FONT_BASE = 16'h0050;
  localparam logic [7:0]  DEC_100   = 8'd100;
  localparam logic [7:0]  DEC_10    = 8'd10;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_RDX, ST_RDY, ST_EXEC, ST_POP,
    ST_BCD, ST_BCDL, ST_ST55, ST_LD65A, ST_LD65B,
    ST_DMODX, ST_DMODY, ST_DROWA, ST_DROWB, ST_DPIXA, ST_DPIXB,
    ST_SCRA, ST_SCRB, ST_DONE
  } c8x_state_t;

endpackage

/* design/c8x_if.sv */
// ----------------------------------------------------------------------------
// c8x_if
// Request and result channels of the CHIP-8 execute unit.
// ----------------------------------------------------------------------------
interface c8x_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] opcode;
  logic [7:0]  rand_byte;
  logic [15:0] keys_down;
  logic [11:0] address;
  logic [7:0]  write_data;

  modport source (output valid, req_type, opcode, rand_byte, keys_down, address,
                  write_data, input ready);
  modport sink (input valid, req_type, opcode, rand_byte, keys_down, address,
                write_data, output ready);
endinterface

interface c8x_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] next_pc;
  logic [15:0] index_value;
  logic [7:0]  flag_value;
  logic [7:0]  read_data;
  logic        waiting_key;
  logic [3:0]  wait_register;
  logic        sound_on;
  logic [7:0]  delay_value;

  modport source (output valid, next_pc, index_value, flag_value, read_data,
                  waiting_key, wait_register, sound_on, delay_value, input ready);
  modport sink (input valid, next_pc, index_value, flag_value, read_data,
                waiting_key, wait_register, sound_on, delay_value, output ready);
endinterface

/* design/c8x_ram.sv */
// ----------------------------------------------------------------------------
// c8x_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module c8x_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/chip8_instruction_execute.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// CHIP-8 execute unit: runs one fetched opcode, or a memory write, screen
// byte read or timer tick, and returns one status result per request.
// ----------------------------------------------------------------------------
// Usage: requests transfer on in_chan (valid/ready); every request yields one
// result on out_chan, held in an output register until it transfers.
// in_chan.ready is high only while the sequencer is idle; one request is
// worked at a time by a small sequencer around one shared subtractor and
// single-port views of the register file, stack, memory and frame buffer.
// Dxyn does a read-modify-write of the frame buffer for each sprite pixel.
// Reset: a clearing pass over the FB_DEPTH = ceil(W*H/8) bytes zeroes the frame
// buffer; requests are taken once it ends. Memory and stack are not cleared.
// When the receiver stalls, a finished result waits in the output register
// while the next request may already be taken and worked; that request then
// waits in its final step until the output register frees.
// ----------------------------------------------------------------------------
module chip8_instruction_execute #(
  parameter int STACK_DEPTH   = 16,
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  c8x_in_if.sink      in_chan,
  c8x_out_if.source   out_chan
);

  import c8x_pkg::*;

  localparam int PIXELS   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int POSW     = $clog2(PIXELS);
  localparam int FB_DEPTH = (PIXELS + 7) / 8;
  localparam int FBAW     = $clog2(FB_DEPTH);
  localparam int PXW      = $clog2(SCREEN_WIDTH);
  localparam int PYW      = $clog2(SCREEN_HEIGHT);
  localparam int SPW      = $clog2(STACK_DEPTH + 1);
  localparam int STAW     = $clog2(STACK_DEPTH);

  c8x_state_t state_r, state_nxt;

  logic [7:0]  gp_r [16];
  logic [7:0]  gp_nxt [16];
  logic [11:0] pc_r, pc_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [7:0]  dly_r, dly_nxt, snd_r, snd_nxt;
  logic        kwf_r, kwf_nxt;
  logic [3:0]  kwr_r, kwr_nxt;

  logic [1:0]  req_r, req_nxt;
  logic [15:0] op_r, op_nxt;
  logic [7:0]  rnd_r, rnd_nxt;
  logic [15:0] keys_r, keys_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic [7:0]  a_r, a_nxt, b_r, b_nxt, w_r, w_nxt;
  logic [3:0]  dig_r, dig_nxt;
  logic        phase_r, phase_nxt;
  logic [3:0]  k_r, k_nxt, row_r, row_nxt;
  logic [2:0]  col_r, col_nxt;
  logic [PXW-1:0] px0_r, px0_nxt, px_r, px_nxt;
  logic [PYW-1:0] py_r, py_nxt;
  logic [7:0]  bits_r, bits_nxt, rd_r, rd_nxt;
  logic        hit_r, hit_nxt, cls_r, cls_nxt;
  logic [FBAW-1:0] cnt_r, cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [11:0] out_pc_r, out_pc_nxt;
  logic [15:0] out_idx_r, out_idx_nxt;
  logic [7:0]  out_flag_r, out_flag_nxt, out_rd_r, out_rd_nxt, out_dly_r, out_dly_nxt;
  logic        out_kwf_r, out_kwf_nxt, out_snd_r, out_snd_nxt;
  logic [3:0]  out_kwr_r, out_kwr_nxt;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              fb_we;
  logic [FBAW-1:0]   fb_waddr, fb_raddr;
  logic [7:0]        fb_wdata, fb_rdata;
  logic              stk_we;
  logic [STAW-1:0]   stk_waddr, stk_raddr;
  logic [11:0]       stk_wdata, stk_rdata;

  logic        in_xfer;
  logic [3:0]  rd_idx;
  logic [7:0]  gp_rd;
  logic [7:0]  sub_k, sub_diff;
  logic        sub_ge;
  logic [POSW-1:0] pos;
  logic [7:0]  pix_mask;
  logic [8:0]  alu_sum;
  logic [3:0]  x_f, y_f;
  logic [7:0]  kk_f;
  logic [11:0] pc_skip, mem_ik;
  logic        key_hit;

  c8x_ram #(.WIDTH(8), .DEPTH(1 << MEM_AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  c8x_ram #(.WIDTH(8), .DEPTH(FB_DEPTH)) u_fb (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .raddr(fb_raddr), .rdata(fb_rdata)
  );

  c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.next_pc       = out_pc_r;
  assign out_chan.index_value   = out_idx_r;
  assign out_chan.flag_value    = out_flag_r;
  assign out_chan.read_data     = out_rd_r;
  assign out_chan.waiting_key   = out_kwf_r;
  assign out_chan.wait_register = out_kwr_r;
  assign out_chan.sound_on      = out_snd_r;
  assign out_chan.delay_value   = out_dly_r;

  assign x_f  = op_r[11:8];
  assign y_f  = op_r[7:4];
  assign kk_f = op_r[7:0];

  always_comb begin
    case (state_r)
      ST_RDY:  rd_idx = y_f;
      ST_ST55: rd_idx = k_r;
      default: rd_idx = x_f;
    endcase
  end
  assign gp_rd = gp_r[rd_idx];

  always_comb begin
    case (state_r)
      ST_DMODX: sub_k = 8'(SCREEN_WIDTH);
      ST_DMODY: sub_k = 8'(SCREEN_HEIGHT);
      default:  sub_k = phase_r ? DEC_10 : DEC_100;
    endcase
  end
  assign sub_ge   = (w_r >= sub_k);
  assign sub_diff = w_r - sub_k;

  assign pos      = POSW'(py_r) * POSW'(SCREEN_WIDTH) + POSW'(px_r);
  assign pix_mask = 8'h80 >> pos[2:0];
  assign alu_sum  = {1'b0, a_r} + {1'b0, b_r};
  assign pc_skip  = pc_r + 12'd2;
  assign mem_ik   = idx_r[11:0] + {8'd0, k_r};
  assign key_hit  = (a_r[7:4] == 4'd0) && keys_r[a_r[3:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pc_r        <= 12'h200;
      idx_r       <= '0;
      sp_r        <= '0;
      dly_r       <= '0;
      snd_r       <= '0;
      kwf_r       <= 1'b0;
      kwr_r       <= '0;
      cnt_r       <= '0;
      cls_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        gp_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      idx_r       <= idx_nxt;
      sp_r        <= sp_nxt;
      dly_r       <= dly_nxt;
      snd_r       <= snd_nxt;
      kwf_r       <= kwf_nxt;
      kwr_r       <= kwr_nxt;
      cnt_r       <= cnt_nxt;
      cls_r       <= cls_nxt;
      out_valid_r <= out_valid_nxt;
      gp_r        <= gp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    op_r       <= op_nxt;
    rnd_r      <= rnd_nxt;
    keys_r     <= keys_nxt;
    addr_r     <= addr_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    w_r        <= w_nxt;
    dig_r      <= dig_nxt;
    phase_r    <= phase_nxt;
    k_r        <= k_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    px0_r      <= px0_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    bits_r     <= bits_nxt;
    hit_r      <= hit_nxt;
    rd_r       <= rd_nxt;
    out_pc_r   <= out_pc_nxt;
    out_idx_r  <= out_idx_nxt;
    out_flag_r <= out_flag_nxt;
    out_rd_r   <= out_rd_nxt;
    out_kwf_r  <= out_kwf_nxt;
    out_kwr_r  <= out_kwr_nxt;
    out_snd_r  <= out_snd_nxt;
    out_dly_r  <= out_dly_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    gp_nxt    = gp_r;
    pc_nxt    = pc_r;
    idx_nxt   = idx_r;
    sp_nxt    = sp_r;
    dly_nxt   = dly_r;
    snd_nxt   = snd_r;
    kwf_nxt   = kwf_r;
    kwr_nxt   = kwr_r;
    req_nxt   = req_r;
    op_nxt    = op_r;
    rnd_nxt   = rnd_r;
    keys_nxt  = keys_r;
    addr_nxt  = addr_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    w_nxt     = w_r;
    dig_nxt   = dig_r;
    phase_nxt = phase_r;
    k_nxt     = k_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    px0_nxt   = px0_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    bits_nxt  = bits_r;
    hit_nxt   = hit_r;
    rd_nxt    = rd_r;
    cls_nxt   = cls_r;
    cnt_nxt   = cnt_r;

    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_pc_nxt    = out_pc_r;
    out_idx_nxt   = out_idx_r;
    out_flag_nxt  = out_flag_r;
    out_rd_nxt    = out_rd_r;
    out_kwf_nxt   = out_kwf_r;
    out_kwr_nxt   = out_kwr_r;
    out_snd_nxt   = out_snd_r;
    out_dly_nxt   = out_dly_r;

    mem_we    = 1'b0;
    mem_waddr = mem_ik;
    mem_wdata = gp_rd;
    mem_raddr = mem_ik;
    fb_we     = 1'b0;
    fb_waddr  = FBAW'(pos >> 3);
    fb_wdata  = fb_rdata ^ pix_mask;
    fb_raddr  = FBAW'(pos >> 3);
    stk_we    = 1'b0;
    stk_waddr = STAW'(sp_r);
    stk_wdata = pc_r;
    stk_raddr = STAW'(sp_r - SPW'(1));

    case (state_r)
      ST_CLEAR: begin
        fb_we    = 1'b1;
        fb_waddr = cnt_r;
        fb_wdata = '0;
        cnt_nxt  = cnt_r + FBAW'(1);
        if (cnt_r == FBAW'(FB_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = cls_r ? ST_DONE : ST_IDLE;
          cls_nxt   = 1'b0;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          req_nxt  = in_chan.req_type;
          op_nxt   = in_chan.opcode;
          rnd_nxt  = in_chan.rand_byte;
          keys_nxt = in_chan.keys_down;
          addr_nxt = in_chan.address;
          rd_nxt   = '0;
          case (in_chan.req_type)
            REQ_EXEC: state_nxt = ST_RDX;
            REQ_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = in_chan.address;
              mem_wdata = in_chan.write_data;
              state_nxt = ST_DONE;
            end
            REQ_READ: state_nxt = ST_SCRA;
            default: begin
              dly_nxt   = dly_r - {7'd0, (dly_r != 8'd0)};
              snd_nxt   = snd_r - {7'd0, (snd_r != 8'd0)};
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_RDX: begin
        a_nxt     = gp_rd;
        state_nxt = ST_RDY;
      end

      ST_RDY: begin
        b_nxt     = gp_rd;
        state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        state_nxt = ST_DONE;
        case (op_r[15:12])
          OPC_SYS: begin
            if (op_r == OP_CLS) begin
              cls_nxt   = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_CLEAR;
            end else if (op_r == OP_RET && sp_r != '0) begin
              sp_nxt    = sp_r - SPW'(1);
              state_nxt = ST_POP;
            end
          end
          OPC_JP: pc_nxt = op_r[11:0];
          OPC_CALL: begin
            if (sp_r < SPW'(STACK_DEPTH)) begin
              stk_we = 1'b1;
              sp_nxt = sp_r + SPW'(1);
            end
            pc_nxt = op_r[11:0];
          end
          OPC_SEI:  if (a_r == kk_f) pc_nxt = pc_skip;
          OPC_SNEI: if (a_r != kk_f) pc_nxt = pc_skip;
          OPC_SER:  if (a_r == b_r) pc_nxt = pc_skip;
          OPC_LDI:  gp_nxt[x_f] = kk_f;
          OPC_ADDI: gp_nxt[x_f] = a_r + kk_f;
          OPC_ALU: begin
            case (op_r[3:0])
              ALU_MOV: gp_nxt[x_f] = b_r;
              ALU_OR:  gp_nxt[x_f] = a_r | b_r;
              ALU_AND: gp_nxt[x_f] = a_r & b_r;
              ALU_XOR: gp_nxt[x_f] = a_r ^ b_r;
              ALU_ADD: begin
                gp_nxt[x_f] = alu_sum[7:0];
                gp_nxt[15]  = {7'd0, alu_sum[8]};
              end
              ALU_SUB: begin
                gp_nxt[x_f] = a_r - b_r;
                gp_nxt[15]  = {7'd0, (a_r > b_r)};
              end
              ALU_SHR: begin
                gp_nxt[x_f] = {1'b0, a_r[7:1]};
                gp_nxt[15]  = {7'd0, a_r[0]};
              end
              ALU_SUBN: begin
                gp_nxt[x_f] = b_r - a_r;
                gp_nxt[15]  = {7'd0, (b_r > a_r)};
              end
              ALU_SHL: begin
                gp_nxt[x_f] = {a_r[6:0], 1'b0};
                gp_nxt[15]  = {7'd0, a_r[7]};
              end
              default: ;
            endcase
          end
          OPC_SNER: if (a_r != b_r) pc_nxt = pc_skip;
          OPC_LDIX: idx_nxt = {4'd0, op_r[11:0]};
          OPC_JPV0: pc_nxt = {4'd0, gp_r[0]} + op_r[11:0];
          OPC_RND:  gp_nxt[x_f] = rnd_r & kk_f;
          OPC_DRW: begin
            w_nxt     = a_r;
            state_nxt = ST_DMODX;
          end
          OPC_KEY: begin
            if (kk_f == KK_SKP && key_hit) pc_nxt = pc_skip;
            else if (kk_f == KK_SKNP && !key_hit) pc_nxt = pc_skip;
          end
          default: begin
            case (kk_f)
              KK_GETDT: gp_nxt[x_f] = dly_r;
              KK_WAIT: begin
                kwf_nxt = 1'b1;
                kwr_nxt = x_f;
              end
              KK_SETDT: dly_nxt = a_r;
              KK_SETST: snd_nxt = a_r;
              KK_ADDI:  idx_nxt = idx_r + {8'd0, a_r};
              KK_FONT:  idx_nxt = FONT_BASE + {10'd0, a_r[3:0], 2'd0} + {12'd0, a_r[3:0]};
              KK_BCD: begin
                w_nxt     = a_r;
                dig_nxt   = '0;
                phase_nxt = 1'b0;
                state_nxt = ST_BCD;
              end
              KK_STORE: begin
                k_nxt     = '0;
                state_nxt = ST_ST55;
              end
              KK_LOAD: begin
                k_nxt     = '0;
                state_nxt = ST_LD65A;
              end
              default: ;
            endcase
          end
        endcase
      end

      ST_POP: begin
        state_nxt = ST_SCRB;
        if (req_r == REQ_EXEC) begin
          pc_nxt    = stk_rdata;
          state_nxt = ST_DONE;
        end
      end

      ST_BCD: begin
        if (sub_ge) begin
          w_nxt   = sub_diff;
          dig_nxt = dig_r + 4'd1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_r[11:0] + {11'd0, phase_r};
          mem_wdata = {4'd0, dig_r};
          dig_nxt   = '0;
          phase_nxt = 1'b1;
          if (phase_r) state_nxt = ST_BCDL;
        end
      end

      ST_BCDL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[11:0] + 12'd2;
        mem_wdata = w_r;
        state_nxt = ST_DONE;
      end

      ST_ST55: begin
        mem_we = 1'b1;
        k_nxt  = k_r + 4'd1;
        if (k_r == x_f) state_nxt = ST_DONE;
      end

      ST_LD65A: state_nxt = ST_LD65B;

      ST_LD65B: begin
        gp_nxt[k_r] = mem_rdata;
        k_nxt       = k_r + 4'd1;
        state_nxt   = (k_r == x_f) ? ST_DONE : ST_LD65A;
      end

      ST_DMODX: begin
        if (sub_ge) begin
          w_nxt = sub_diff;
        end else begin
          px0_nxt   = PXW'(w_r);
          w_nxt     = b_r;
          state_nxt = ST_DMODY;
        end
      end

      ST_DMODY: begin
        if (sub_ge) begin
          w_nxt = sub_diff;
        end else begin
          py_nxt    = PYW'(w_r);
          row_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = ST_DROWA;
        end
      end

      ST_DROWA: begin
        mem_raddr = idx_r[11:0] + {8'd0, row_r};
        if (row_r == op_r[3:0]) begin
          gp_nxt[15] = {7'd0, hit_r};
          state_nxt  = ST_DONE;
        end else begin
          state_nxt = ST_DROWB;
        end
      end

      ST_DROWB: begin
        bits_nxt  = mem_rdata;
        col_nxt   = '0;
        px_nxt    = px0_r;
        state_nxt = ST_DPIXA;
      end

      ST_DPIXA: state_nxt = ST_DPIXB;

      ST_DPIXB: begin
        if (bits_r[3'd7 - col_r]) begin
          fb_we   = 1'b1;
          hit_nxt = hit_r | ((fb_rdata & pix_mask) != 8'd0);
        end
        col_nxt = col_r + 3'd1;
        px_nxt  = (px_r == PXW'(SCREEN_WIDTH - 1)) ? '0 : px_r + PXW'(1);
        if (col_r == 3'd7) begin
          row_nxt   = row_r + 4'd1;
          py_nxt    = (py_r == PYW'(SCREEN_HEIGHT - 1)) ? '0 : py_r + PYW'(1);
          state_nxt = ST_DROWA;
        end else begin
          state_nxt = ST_DPIXA;
        end
      end

      ST_SCRA: begin
        fb_raddr = FBAW'(addr_r);
        if (addr_r < 12'(FB_DEPTH)) state_nxt = ST_SCRB;
        else state_nxt = ST_DONE;
      end

      ST_SCRB: begin
        rd_nxt    = fb_rdata;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_pc_nxt    = pc_r;
          out_idx_nxt   = idx_r;
          out_flag_nxt  = gp_r[15];
          out_rd_nxt    = rd_r;
          out_kwf_nxt   = kwf_r;
          out_kwr_nxt   = kwr_r;
          out_snd_nxt   = (snd_r != 8'd0);
          out_dly_nxt   = dly_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_chan.ready)
    else $error("ready after request transfer");

  a_fb_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !fb_we)
    else $error("frame buffer write while idle");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside final step");
`endif

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the CHIP-8 execute unit. Requests go in through the request
// channel in random bursts while the status channel stalls on its own pattern.
// A predictor in the bench keeps the registers, stack, memory, frame buffer
// and timers, works out the status of every request it sends, and compares
// each status transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import c8x_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] op;
    logic [7:0]  rnd;
    logic [15:0] keys;
    logic [11:0] addr;
    logic [7:0]  wdata;
  } request_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [15:0] index_value;
    logic [7:0]  flag_value;
    logic [7:0]  read_data;
    logic        waiting_key;
    logic [3:0]  wait_register;
    logic        sound_on;
    logic [7:0]  delay_value;
  } status_t;

  logic clk = 1'b0;
  logic rst_n;

  c8x_in_if  req_if ();
  c8x_out_if sts_if ();

  chip8_instruction_execute dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (sts_if)
  );

  always #5 clk = ~clk;

  // machine state as the bench sees it
  logic [7:0]  vreg [16];
  logic [11:0] pc;
  logic [15:0] idx;
  logic [11:0] call_stack [16];
  int          sp;
  logic [7:0]  ram [4096];
  bit          ram_known [4096];
  bit          pixels [2048];
  logic [7:0]  dtimer;
  logic [7:0]  stimer;
  logic        key_wait;
  logic [3:0]  key_reg;

  status_t pending_status [$];
  int      errors;
  int      burst_left;
  bit      gaps_on;
  bit      hold_req;

  function automatic void ram_put(int a, logic [7:0] v);
    ram[a & 4095] = v;
    ram_known[a & 4095] = 1'b1;
  endfunction

  function automatic void run_alu(logic [3:0] x, logic [3:0] y, logic [3:0] n);
    logic [7:0] a, b, r;
    logic       f;
    a = vreg[x];
    b = vreg[y];
    case (n)
      ALU_MOV: begin vreg[x] = b; return; end
      ALU_OR:  begin vreg[x] = a | b; return; end
      ALU_AND: begin vreg[x] = a & b; return; end
      ALU_XOR: begin vreg[x] = a ^ b; return; end
      ALU_ADD: begin r = a + b; f = (9'(a) + 9'(b)) > 9'd255; end
      ALU_SUB: begin r = a - b; f = a > b; end
      ALU_SHR: begin r = a >> 1; f = a[0]; end
      ALU_SUBN: begin r = b - a; f = b > a; end
      ALU_SHL: begin r = a << 1; f = a[7]; end
      default: return;
    endcase
    vreg[x] = r;
    vreg[15] = {7'd0, f};
  endfunction

  function automatic void run_sprite(logic [3:0] x, logic [3:0] y, logic [3:0] n);
    int bx, by, px, py, pos;
    logic [7:0] bits;
    bit hit, pix;
    bx = vreg[x];
    by = vreg[y];
    hit = 0;
    for (int row = 0; row < n; row++) begin
      bits = ram[(idx + row) & 4095];
      py = (by + row) % 32;
      for (int col = 0; col < 8; col++) begin
        px = (bx + col) % 64;
        pos = py * 64 + px;
        pix = bits[7 - col];
        hit |= pixels[pos] & pix;
        pixels[pos] ^= pix;
      end
    end
    vreg[15] = {7'd0, hit};
  endfunction

  function automatic void run_misc(logic [3:0] x, logic [7:0] kk);
    logic [7:0] v;
    v = vreg[x];
    case (kk)
      KK_GETDT: vreg[x] = dtimer;
      KK_WAIT:  begin key_wait = 1'b1; key_reg = x; end
      KK_SETDT: dtimer = v;
      KK_SETST: stimer = v;
      KK_ADDI:  idx = idx + {8'd0, v};
      KK_FONT:  idx = FONT_BASE + 16'(v[3:0]) * 16'd5;
      KK_BCD: begin
        ram_put(idx, 8'(v / 8'd100));
        ram_put(idx + 1, 8'((v / 8'd10) % 8'd10));
        ram_put(idx + 2, 8'(v % 8'd10));
      end
      KK_STORE: for (int k = 0; k <= x; k++) ram_put(idx + k, vreg[k]);
      KK_LOAD:  for (int k = 0; k <= x; k++) vreg[k] = ram[(idx + k) & 4095];
      default: ;
    endcase
  endfunction

  function automatic void run_opcode(logic [15:0] op, logic [7:0] rnd, logic [15:0] keys);
    logic [3:0] x, y, n;
    logic [7:0] kk;
    bit down;
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    kk = op[7:0];
    case (op[15:12])
      OPC_SYS: begin
        if (op == OP_CLS) foreach (pixels[i]) pixels[i] = 0;
        else if (op == OP_RET && sp > 0) begin
          sp--;
          pc = call_stack[sp];
        end
      end
      OPC_JP: pc = op[11:0];
      OPC_CALL: begin
        if (sp < 16) begin
          call_stack[sp] = pc;
          sp++;
        end
        pc = op[11:0];
      end
      OPC_SEI:  if (vreg[x] == kk) pc = pc + 12'd2;
      OPC_SNEI: if (vreg[x] != kk) pc = pc + 12'd2;
      OPC_SER:  if (vreg[x] == vreg[y]) pc = pc + 12'd2;
      OPC_LDI:  vreg[x] = kk;
      OPC_ADDI: vreg[x] = vreg[x] + kk;
      OPC_ALU:  run_alu(x, y, n);
      OPC_SNER: if (vreg[x] != vreg[y]) pc = pc + 12'd2;
      OPC_LDIX: idx = {4'd0, op[11:0]};
      OPC_JPV0: pc = op[11:0] + {4'd0, vreg[0]};
      OPC_RND:  vreg[x] = rnd & kk;
      OPC_DRW:  run_sprite(x, y, n);
      OPC_KEY: begin
        down = vreg[x] < 8'd16 && keys[vreg[x][3:0]];
        if (kk == KK_SKP && down) pc = pc + 12'd2;
        else if (kk == KK_SKNP && !down) pc = pc + 12'd2;
      end
      default: run_misc(x, kk);
    endcase
  endfunction

  function automatic status_t predict_status(request_t r);
    status_t s;
    logic [7:0] rd;
    int p;
    rd = '0;
    case (r.kind)
      REQ_EXEC:  run_opcode(r.op, r.rnd, r.keys);
      REQ_WRITE: ram_put(r.addr, r.wdata);
      REQ_READ: begin
        for (int k = 0; k < 8; k++) begin
          p = r.addr * 8 + k;
          rd = {rd[6:0], (p < 2048) ? pixels[p] : 1'b0};
        end
      end
      default: begin
        if (dtimer != 0) dtimer--;
        if (stimer != 0) stimer--;
      end
    endcase
    s.next_pc = pc;
    s.index_value = idx;
    s.flag_value = vreg[15];
    s.read_data = rd;
    s.waiting_key = key_wait;
    s.wait_register = key_reg;
    s.sound_on = stimer != 0;
    s.delay_value = dtimer;
    return s;
  endfunction

  task automatic send_request(request_t r);
    req_if.req_type   <= r.kind;
    req_if.opcode     <= r.op;
    req_if.rand_byte  <= r.rnd;
    req_if.keys_down  <= r.keys;
    req_if.address    <= r.addr;
    req_if.write_data <= r.wdata;
    req_if.valid      <= 1'b1;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    pending_status.push_back(predict_status(r));
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) begin
          req_if.valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
  endtask

  function automatic request_t random_request(logic [1:0] kind);
    request_t r;
    r.kind = kind;
    r.op = 16'($urandom);
    r.rnd = 8'($urandom);
    r.keys = 16'($urandom);
    r.addr = 12'($urandom);
    r.wdata = 8'($urandom);
    return r;
  endfunction

  // fill any never-written byte that an opcode is about to read
  task automatic exec_op(logic [15:0] op);
    request_t r;
    int cnt;
    cnt = 0;
    if (op[15:12] == OPC_DRW) cnt = int'(op[3:0]);
    else if (op[15:12] == OPC_MISC && op[7:0] == KK_LOAD) cnt = int'(op[11:8]) + 1;
    for (int k = 0; k < cnt; k++) begin
      if (!ram_known[(idx + k) & 4095]) begin
        r = random_request(REQ_WRITE);
        r.addr = 12'((idx + k) & 4095);
        send_request(r);
      end
    end
    r = random_request(REQ_EXEC);
    r.op = op;
    send_request(r);
  endtask

  task automatic send_kind(logic [1:0] kind, logic [11:0] addr);
    request_t r;
    r = random_request(kind);
    r.addr = addr;
    send_request(r);
  endtask

  function automatic logic [15:0] random_opcode();
    logic [15:0] op;
    logic [7:0] misc [11];
    misc = '{KK_GETDT, KK_WAIT, KK_SETDT, KK_SETST, KK_ADDI, KK_FONT, KK_BCD,
             KK_STORE, KK_LOAD, KK_SKP, KK_SKNP};
    op = 16'($urandom);
    if ($urandom_range(0, 9) == 0) return op;
    case (op[15:12])
      OPC_SYS: case ($urandom_range(0, 7))
        0: op = OP_CLS;
        1, 2: op = op;
        default: op = OP_RET;
      endcase
      OPC_ALU: begin
        op[3:0] = 4'($urandom_range(0, 8));
        if (op[3:0] == 4'h8) op[3:0] = ALU_SHL;
      end
      OPC_KEY: op[7:0] = $urandom_range(0, 1) ? KK_SKP : KK_SKNP;
      OPC_MISC: op[7:0] = misc[$urandom_range(0, 8)];
      OPC_SEI, OPC_SNEI: if ($urandom_range(0, 1)) op[7:0] = vreg[op[11:8]];
      default: ;
    endcase
    return op;
  endfunction

  task automatic test_alu_flags();
    exec_op({OPC_SYS, 12'h0E0});
    exec_op({OPC_LDI, 4'h1, 8'hFF});
    exec_op({OPC_LDI, 4'h2, 8'h01});
    exec_op({OPC_ALU, 4'h1, 4'h2, ALU_ADD});
    exec_op({OPC_ALU, 4'h1, 4'h2, ALU_SUB});
    exec_op({OPC_ALU, 4'h1, 4'h2, ALU_SUBN});
    exec_op({OPC_LDI, 4'h3, 8'h81});
    exec_op({OPC_ALU, 4'h3, 4'h0, ALU_SHR});
    exec_op({OPC_LDI, 4'h3, 8'h81});
    exec_op({OPC_ALU, 4'h3, 4'h0, ALU_SHL});
    exec_op({OPC_LDI, 4'hF, 8'hC8});
    exec_op({OPC_ALU, 4'hF, 4'h1, ALU_ADD});
    exec_op({OPC_ALU, 4'h1, 4'h2, 4'h9});
    exec_op({OPC_RND, 4'h4, 8'hF0});
  endtask

  task automatic test_stack_and_jumps();
    exec_op(OP_RET);
    for (int k = 0; k < 17; k++) exec_op({OPC_CALL, 12'h300 + 12'(k * 2)});
    exec_op(OP_RET);
    exec_op({OPC_LDI, 4'h0, 8'hFF});
    exec_op({OPC_JPV0, 12'hFFF});
    exec_op({OPC_JP, 12'hFFE});
    exec_op({OPC_SEI, 4'h0, 8'hFF});
    for (int k = 0; k < 17; k++) exec_op(OP_RET);
  endtask

  task automatic test_draw_and_screen();
    exec_op({OPC_LDI, 4'h5, 8'd61});
    exec_op({OPC_LDI, 4'h6, 8'd30});
    exec_op({OPC_LDIX, 12'hFF8});
    exec_op({OPC_DRW, 4'h5, 4'h6, 4'hF});
    exec_op({OPC_DRW, 4'h5, 4'h6, 4'h3});
    exec_op({OPC_LDI, 4'h5, 8'hFF});
    exec_op({OPC_DRW, 4'h5, 4'h5, 4'h1});
    send_kind(REQ_READ, 12'd255);
    send_kind(REQ_READ, 12'd247);
    send_kind(REQ_READ, 12'd300);
    send_kind(REQ_READ, 12'hFFF);
    exec_op({OPC_SYS, 12'h0E0});
    send_kind(REQ_READ, 12'd255);
  endtask

  task automatic test_keys_timers_memory();
    exec_op({OPC_LDI, 4'h7, 8'd15});
    exec_op({OPC_KEY, 4'h7, KK_SKP});
    exec_op({OPC_KEY, 4'h7, KK_SKNP});
    exec_op({OPC_LDI, 4'h7, 8'd200});
    exec_op({OPC_KEY, 4'h7, KK_SKP});
    exec_op({OPC_KEY, 4'h7, KK_SKNP});
    exec_op({OPC_MISC, 4'hB, KK_WAIT});
    exec_op({OPC_MISC, 4'h7, KK_SETDT});
    exec_op({OPC_MISC, 4'h2, KK_SETST});
    send_kind(REQ_TICK, 12'd0);
    send_kind(REQ_TICK, 12'd0);
    exec_op({OPC_MISC, 4'h8, KK_GETDT});
    exec_op({OPC_MISC, 4'h7, KK_FONT});
    exec_op({OPC_LDIX, 12'hFFE});
    exec_op({OPC_MISC, 4'h7, KK_BCD});
    exec_op({OPC_MISC, 4'hF, KK_STORE});
    exec_op({OPC_MISC, 4'hF, KK_LOAD});
    exec_op({OPC_MISC, 4'h3, 8'h42});
  endtask

  task automatic test_index_wrap();
    exec_op({OPC_LDIX, 12'hFFF});
    exec_op({OPC_LDI, 4'h0, 8'hFF});
    for (int k = 0; k < 250; k++) exec_op({OPC_MISC, 4'h0, KK_ADDI});
  endtask

  task automatic test_random(int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) exec_op(random_opcode());
      else if (pick < 75) send_kind(REQ_WRITE, 12'($urandom));
      else if (pick < 90)
        send_kind(REQ_READ, 12'($urandom_range(0, 9) ? $urandom_range(0, 255) : $urandom));
      else send_kind(REQ_TICK, 12'($urandom));
    end
  endtask

  task automatic test_backpressure();
    gaps_on = 0;
    hold_req = 1;
    test_random(30);
    gaps_on = 1;
  endtask

  task automatic check_status(status_t got);
    status_t want;
    if (pending_status.size() == 0) begin
      $error("status transfer with nothing expected");
      errors++;
      return;
    end
    want = pending_status.pop_front();
    if (got.next_pc !== want.next_pc) begin
      $error("next_pc: expected %h, got %h", want.next_pc, got.next_pc); errors++;
    end
    if (got.index_value !== want.index_value) begin
      $error("index_value: expected %h, got %h", want.index_value, got.index_value); errors++;
    end
    if (got.flag_value !== want.flag_value) begin
      $error("flag_value: expected %h, got %h", want.flag_value, got.flag_value); errors++;
    end
    if (got.read_data !== want.read_data) begin
      $error("read_data: expected %h, got %h", want.read_data, got.read_data); errors++;
    end
    if (got.waiting_key !== want.waiting_key) begin
      $error("waiting_key: expected %h, got %h", want.waiting_key, got.waiting_key); errors++;
    end
    if (got.wait_register !== want.wait_register) begin
      $error("wait_register: expected %h, got %h", want.wait_register, got.wait_register);
      errors++;
    end
    if (got.sound_on !== want.sound_on) begin
      $error("sound_on: expected %h, got %h", want.sound_on, got.sound_on); errors++;
    end
    if (got.delay_value !== want.delay_value) begin
      $error("delay_value: expected %h, got %h", want.delay_value, got.delay_value); errors++;
    end
  endtask

  initial begin
    int hold_cnt;
    int cyc;
    int mode;
    hold_cnt = 0;
    cyc = 0;
    mode = 0;
    sts_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && sts_if.valid && sts_if.ready)
        check_status({sts_if.next_pc, sts_if.index_value, sts_if.flag_value,
                      sts_if.read_data, sts_if.waiting_key, sts_if.wait_register,
                      sts_if.sound_on, sts_if.delay_value});
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        sts_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: sts_if.ready <= 1'b1;
          1: sts_if.ready <= 1'($urandom_range(0, 1));
          default: sts_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    foreach (vreg[i]) vreg[i] = 0;
    foreach (call_stack[i]) call_stack[i] = 0;
    foreach (ram[i]) begin
      ram[i] = 0;
      ram_known[i] = 0;
    end
    foreach (pixels[i]) pixels[i] = 0;
    pc = 12'h200;
    idx = 0;
    sp = 0;
    dtimer = 0;
    stimer = 0;
    key_wait = 0;
    key_reg = 0;
    errors = 0;
    burst_left = 4;
    gaps_on = 1;
    hold_req = 0;
    rst_n <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.req_type <= REQ_EXEC;
    req_if.opcode <= '0;
    req_if.rand_byte <= '0;
    req_if.keys_down <= '0;
    req_if.address <= '0;
    req_if.write_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_alu_flags();
    test_stack_and_jumps();
    test_draw_and_screen();
    test_keys_timers_memory();
    test_index_wrap();
    test_random(60);
    test_backpressure();
    test_random(60);
    @(posedge clk);
    req_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* chip8_instruction_execute.f */
design/c8x_pkg.sv
design/c8x_if.sv
design/c8x_ram.sv
design/chip8_instruction_execute.sv
test/tb_top.sv
